// ===== rtl/core/mtwd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwd_pkg: shared definitions for the missing-tooth wheel decoder
// Register indexes, reset values, ratio window constants and sizes.
// ----------------------------------------------------------------------------
package mtwd_pkg;

   localparam int PERIOD_WIDTH_DEFAULT = 32;

   // Configuration register indexes
   localparam logic [2:0] REG_CLOCK_HZ      = 3'd0;
   localparam logic [2:0] REG_TEETH_PER_REV = 3'd1;
   localparam logic [2:0] REG_COUNT_LIMIT   = 3'd2;
   localparam logic [2:0] REG_MARKER_EVERY  = 3'd3;
   localparam logic [2:0] REG_MARKER_LIMIT  = 3'd4;

   localparam int CLOCK_WIDTH = 30;
   localparam int COUNT_WIDTH = 8;

   localparam logic [CLOCK_WIDTH-1:0] CLOCK_HZ_RESET      = 30'd200000000;
   localparam logic [COUNT_WIDTH-1:0] TEETH_PER_REV_RESET = 8'd36;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT_RESET   = 8'd33;
   localparam logic [COUNT_WIDTH-1:0] MARKER_EVERY_RESET  = 8'd5;
   localparam logic [COUNT_WIDTH-1:0] MARKER_LIMIT_RESET  = 8'd31;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 8'hFF;
   localparam logic [31:0]            SPEED_MAX = 32'hFFFF_FFFF;

   // Divider passes: full clock numerator, or a tooth count for the marker test
   localparam int ITER_WIDTH   = 5;
   localparam int SPEED_STEPS  = CLOCK_WIDTH;
   localparam int MARKER_STEPS = COUNT_WIDTH;

   // Ratio slots, in tenths, walked by the compare sequencer
   localparam int RATIO_WIDTH = 6;
   localparam logic [2:0] SLOT_SPEED_LO = 3'd0;
   localparam logic [2:0] SLOT_SPEED_HI = 3'd1;
   localparam logic [2:0] SLOT_HALF_LO  = 3'd2;
   localparam logic [2:0] SLOT_HALF_HI  = 3'd3;
   localparam logic [2:0] SLOT_GAP_LO   = 3'd4;
   localparam logic [2:0] SLOT_SYNC_LO  = 3'd5;
   localparam logic [2:0] SLOT_SYNC_HI  = 3'd6;
   localparam logic [2:0] SLOT_GAP_HI   = 3'd7;

   function automatic logic [RATIO_WIDTH-1:0] ratio_tenths(input logic [2:0] slot);
      logic [RATIO_WIDTH-1:0] k;
      case (slot)
         SLOT_SPEED_LO: k = 6'd8;
         SLOT_SPEED_HI: k = 6'd12;
         SLOT_HALF_LO:  k = 6'd18;
         SLOT_HALF_HI:  k = 6'd22;
         SLOT_GAP_LO:   k = 6'd23;
         SLOT_SYNC_LO:  k = 6'd25;
         SLOT_SYNC_HI:  k = 6'd35;
         SLOT_GAP_HI:   k = 6'd37;
         default:       k = 6'd0;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/missing_tooth_wheel_decoder.sv =====
// ----------------------------------------------------------------------------
// missing_tooth_wheel_decoder: trigger wheel gap detector and speed decoder
// Windows each tooth period against the previous one, tracks sync, tooth
// count and markers, and divides the timer clock down to a held wheel speed.
// ----------------------------------------------------------------------------
// One tooth period is taken per transfer on req_, and one result per tooth is
// offered on rsp_. A tooth passes one ratio multiply-compare walked over eight
// window edges, a speed division when its ratio calls for a new speed (skipped
// when the divisor is zero), and a marker test, then waits on rsp_stall. One
// restoring divider serves both and gives one quotient bit a cycle (30 bits for
// the speed, 8 for the marker remainder). req_stall stays high from the
// transfer until the result has been taken. Configuration writes are always
// ready and should be made while no tooth is in flight.
module missing_tooth_wheel_decoder #(
   parameter int PERIOD_WIDTH = mtwd_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_tooth_period,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_speed_rpm,
   output logic        rsp_gap_event,
   output logic        rsp_marker_event,
   output logic [7:0]  rsp_tooth_index,
   output logic        rsp_synced,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int PW  = PERIOD_WIDTH;
   localparam int CW  = PW + 6;              // ratio products and 10x period
   localparam int DW  = PW + 8;              // period times teeth
   localparam int QW  = mtwd_pkg::CLOCK_WIDTH;
   localparam int NW  = mtwd_pkg::COUNT_WIDTH;
   localparam int IW  = mtwd_pkg::ITER_WIDTH;
   localparam int SW  = QW + 6;              // quotient times 60

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CMP    = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_SCALE  = 3'd5;
   localparam logic [2:0] ST_MARK   = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [QW-1:0] clock_hz_ff, clock_hz_in;
   logic [NW-1:0] teeth_ff, teeth_in;
   logic [NW-1:0] count_limit_ff, count_limit_in;
   logic [NW-1:0] marker_every_ff, marker_every_in;
   logic [NW-1:0] marker_limit_ff, marker_limit_in;

   logic [PW-1:0] prev_ff, prev_in;
   logic [NW-1:0] count_ff, count_in;
   logic          sync_ff, sync_in;
   logic [31:0]   speed_ff, speed_in;
   logic          gap_ff, gap_in;
   logic          marker_ff, marker_in;

   logic [PW-1:0] cur_ff, cur_in;
   logic [CW-1:0] c10_ff, c10_in;
   logic [2:0]    slot_ff, slot_in;
   logic [7:0]    lt_ff, lt_in;
   logic [7:0]    gt_ff, gt_in;
   logic [QW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic          speed_mode_ff, speed_mode_in;

   logic [CW-1:0] ratio_prod;
   logic [DW:0]   rem_shift;
   logic [DW:0]   rem_diff;
   logic [DW-1:0] rem_next;
   logic [DW-1:0] den_prod;
   logic [SW-1:0] scaled;
   logic          win_speed, win_half, win_gap, win_sync;
   logic          sync_next;
   logic [NW-1:0] count_next;

   // Shared ratio multiply and divider subtract
   assign ratio_prod = CW'(mtwd_pkg::ratio_tenths(slot_ff)) * CW'(prev_ff);
   assign rem_shift  = {rem_ff, num_ff[QW-1]};
   assign rem_diff   = rem_shift - {1'b0, den_ff};
   assign rem_next   = rem_diff[DW] ? rem_shift[DW-1:0] : rem_diff[DW-1:0];
   assign den_prod   = DW'(den_ff[PW-1:0]) * DW'(teeth_ff);
   assign scaled     = (SW'(num_ff) << 6) - (SW'(num_ff) << 2);

   assign win_speed = lt_ff[mtwd_pkg::SLOT_SPEED_LO] & gt_ff[mtwd_pkg::SLOT_SPEED_HI];
   assign win_half  = lt_ff[mtwd_pkg::SLOT_HALF_LO]  & gt_ff[mtwd_pkg::SLOT_HALF_HI];
   assign win_gap   = lt_ff[mtwd_pkg::SLOT_GAP_LO]   & gt_ff[mtwd_pkg::SLOT_GAP_HI];
   assign win_sync  = lt_ff[mtwd_pkg::SLOT_SYNC_LO]  & gt_ff[mtwd_pkg::SLOT_SYNC_HI];

   always_comb begin
      state_in        = state_ff;
      clock_hz_in     = clock_hz_ff;
      teeth_in        = teeth_ff;
      count_limit_in  = count_limit_ff;
      marker_every_in = marker_every_ff;
      marker_limit_in = marker_limit_ff;
      prev_in         = prev_ff;
      count_in        = count_ff;
      sync_in         = sync_ff;
      speed_in        = speed_ff;
      gap_in          = gap_ff;
      marker_in       = marker_ff;
      cur_in          = cur_ff;
      c10_in          = c10_ff;
      slot_in         = slot_ff;
      lt_in           = lt_ff;
      gt_in           = gt_ff;
      num_in          = num_ff;
      rem_in          = rem_ff;
      den_in          = den_ff;
      iter_in         = iter_ff;
      speed_mode_in   = speed_mode_ff;
      sync_next       = sync_ff;
      count_next      = count_ff;

      if (csr_valid) begin
         case (csr_index)
            mtwd_pkg::REG_CLOCK_HZ:      clock_hz_in     = csr_wdata[QW-1:0];
            mtwd_pkg::REG_TEETH_PER_REV: teeth_in        = csr_wdata[NW-1:0];
            mtwd_pkg::REG_COUNT_LIMIT:   count_limit_in  = csr_wdata[NW-1:0];
            mtwd_pkg::REG_MARKER_EVERY:  marker_every_in = csr_wdata[NW-1:0];
            mtwd_pkg::REG_MARKER_LIMIT:  marker_limit_in = csr_wdata[NW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_tooth_period[PW-1:0];
               c10_in   = (CW'(req_tooth_period[PW-1:0]) << 3)
                        + (CW'(req_tooth_period[PW-1:0]) << 1);
               slot_in  = 3'd0;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            lt_in[slot_ff] = ratio_prod < c10_ff;
            gt_in[slot_ff] = ratio_prod > c10_ff;
            slot_in        = slot_ff + 3'd1;
            if (slot_ff == 3'd7) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            sync_next     = sync_ff | win_sync;
            sync_in       = sync_next;
            prev_in       = cur_ff;
            gap_in        = 1'b0;
            speed_mode_in = 1'b0;
            if (win_speed) begin
               speed_mode_in = 1'b1;
               den_in        = DW'(cur_ff);
            end else if (win_half) begin
               speed_mode_in = 1'b1;
               den_in        = DW'(cur_ff >> 1);
            end else if (win_gap || count_ff == count_limit_ff) begin
               gap_in     = 1'b1;
               count_next = '0;
            end
            // advance once synced, hold at full scale
            if (sync_next && count_next != mtwd_pkg::COUNT_MAX) begin
               count_next = count_next + NW'(1);
            end
            count_in = count_next;
            state_in = speed_mode_in ? ST_MUL : ST_MARK;
         end
         ST_MUL: begin
            if (den_prod == '0) begin
               speed_in      = mtwd_pkg::SPEED_MAX;
               speed_mode_in = 1'b0;
               state_in      = ST_MARK;
            end else begin
               den_in   = den_prod;
               num_in   = clock_hz_ff;
               rem_in   = '0;
               iter_in  = IW'(mtwd_pkg::SPEED_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            num_in  = {num_ff[QW-2:0], ~rem_diff[DW]};
            iter_in = iter_ff - IW'(1);
            if (iter_ff == '0) begin
               if (speed_mode_ff) begin
                  state_in = ST_SCALE;
               end else begin
                  marker_in = (rem_next == '0);
                  state_in  = ST_OUT;
               end
            end
         end
         ST_SCALE: begin
            speed_in      = (scaled[SW-1:32] != '0) ? mtwd_pkg::SPEED_MAX : scaled[31:0];
            speed_mode_in = 1'b0;
            state_in      = ST_MARK;
         end
         ST_MARK: begin
            if (marker_every_ff != '0 && count_ff != '0 && count_ff < marker_limit_ff) begin
               // count sits in the top bits so only its own bits are stepped
               num_in   = {count_ff, {(QW-NW){1'b0}}};
               rem_in   = '0;
               den_in   = DW'(marker_every_ff);
               iter_in  = IW'(mtwd_pkg::MARKER_STEPS - 1);
               state_in = ST_DIV;
            end else begin
               marker_in = 1'b0;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         clock_hz_ff     <= mtwd_pkg::CLOCK_HZ_RESET;
         teeth_ff        <= mtwd_pkg::TEETH_PER_REV_RESET;
         count_limit_ff  <= mtwd_pkg::COUNT_LIMIT_RESET;
         marker_every_ff <= mtwd_pkg::MARKER_EVERY_RESET;
         marker_limit_ff <= mtwd_pkg::MARKER_LIMIT_RESET;
         prev_ff         <= '0;
         count_ff        <= '0;
         sync_ff         <= 1'b0;
         speed_ff        <= '0;
         gap_ff          <= 1'b0;
         marker_ff       <= 1'b0;
         speed_mode_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clock_hz_ff     <= clock_hz_in;
         teeth_ff        <= teeth_in;
         count_limit_ff  <= count_limit_in;
         marker_every_ff <= marker_every_in;
         marker_limit_ff <= marker_limit_in;
         prev_ff         <= prev_in;
         count_ff        <= count_in;
         sync_ff         <= sync_in;
         speed_ff        <= speed_in;
         gap_ff          <= gap_in;
         marker_ff       <= marker_in;
         speed_mode_ff   <= speed_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      c10_ff  <= c10_in;
      slot_ff <= slot_in;
      lt_ff   <= lt_in;
      gt_ff   <= gt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      iter_ff <= iter_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_speed_rpm    = speed_ff;
   assign rsp_gap_event    = gap_ff;
   assign rsp_marker_event = marker_ff;
   assign rsp_tooth_index  = count_ff;
   assign rsp_synced       = sync_ff;
   assign csr_ready        = 1'b1;

endmodule

// ===== tb/missing_tooth_wheel_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// missing_tooth_wheel_decoder_test: self-checking bench for the wheel decoder
// Drives tooth periods through directed ratio-window edges, register extremes,
// synthetic trigger wheels with missing teeth, count saturation and noise.
// A local decoder model predicts each result, which is compared in order.
// ----------------------------------------------------------------------------
module missing_tooth_wheel_decoder_test;

   typedef struct packed {
      logic [31:0] speed_rpm;
      logic        gap_event;
      logic        marker_event;
      logic [7:0]  tooth_index;
      logic        synced;
   } tooth_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_tooth_period = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_speed_rpm;
   logic        rsp_gap_event;
   logic        rsp_marker_event;
   logic [7:0]  rsp_tooth_index;
   logic        rsp_synced;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   missing_tooth_wheel_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tooth_period (req_tooth_period),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_speed_rpm    (rsp_speed_rpm),
      .rsp_gap_event    (rsp_gap_event),
      .rsp_marker_event (rsp_marker_event),
      .rsp_tooth_index  (rsp_tooth_index),
      .rsp_synced       (rsp_synced),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Decoder shadow: configuration and state
   logic [mtwd_pkg::CLOCK_WIDTH-1:0] cfg_clock_hz     = mtwd_pkg::CLOCK_HZ_RESET;
   logic [7:0]                       cfg_teeth        = mtwd_pkg::TEETH_PER_REV_RESET;
   logic [7:0]                       cfg_count_limit  = mtwd_pkg::COUNT_LIMIT_RESET;
   logic [7:0]                       cfg_marker_every = mtwd_pkg::MARKER_EVERY_RESET;
   logic [7:0]                       cfg_marker_limit = mtwd_pkg::MARKER_LIMIT_RESET;
   logic [31:0]                      last_period      = '0;
   logic [7:0]                       tooth_count      = '0;
   logic                             sync_seen        = 1'b0;
   logic [31:0]                      held_speed       = '0;

   tooth_result_type pending_results[$];
   int unsigned      error_count   = 0;
   int unsigned      results_taken = 0;
   bit               idle_enable   = 1'b1;

   function automatic logic ratio_between(input logic [63:0] prev, input logic [63:0] cur,
                                          input logic [63:0] lo, input logic [63:0] hi);
      logic [63:0] cur10;
      cur10 = cur * 10;
      return (lo * prev < cur10) && (cur10 < hi * prev);
   endfunction

   function automatic logic [31:0] wheel_speed(input logic [63:0] period);
      logic [63:0] divisor;
      logic [63:0] rpm;
      divisor = period * {56'd0, cfg_teeth};
      if (divisor == 0)
         return mtwd_pkg::SPEED_MAX;
      rpm = ({34'd0, cfg_clock_hz} / divisor) * 60;
      if (rpm > {32'd0, mtwd_pkg::SPEED_MAX})
         rpm = {32'd0, mtwd_pkg::SPEED_MAX};
      return rpm[31:0];
   endfunction

   task automatic decode_tooth(input logic [31:0] period);
      logic [63:0]      prev;
      logic [63:0]      cur;
      tooth_result_type r;
      prev = {32'd0, last_period};
      cur = {32'd0, period};
      r = '0;
      last_period = period;
      if (ratio_between(prev, cur, 25, 35))
         sync_seen = 1'b1;
      if (ratio_between(prev, cur, 8, 12)) begin
         held_speed = wheel_speed(cur);
      end else if (ratio_between(prev, cur, 18, 22)) begin
         held_speed = wheel_speed(cur >> 1);
      end else if (ratio_between(prev, cur, 23, 37) || tooth_count == cfg_count_limit) begin
         r.gap_event = 1'b1;
         tooth_count = '0;
      end
      if (sync_seen && tooth_count != mtwd_pkg::COUNT_MAX)
         tooth_count++;
      r.marker_event = cfg_marker_every != 0 && tooth_count != 0
                       && tooth_count < cfg_marker_limit
                       && (tooth_count % cfg_marker_every) == 0;
      r.speed_rpm = held_speed;
      r.tooth_index = tooth_count;
      r.synced = sync_seen;
      pending_results.push_back(r);
   endtask

   // Hold valid across back-to-back transfers; drop it only for an idle gap
   task automatic send_tooth(input logic [31:0] period);
      if (idle_enable && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tooth_period <= period;
      do @(posedge clock); while (req_stall);
      decode_tooth(period);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mtwd_pkg::REG_CLOCK_HZ:      cfg_clock_hz = data[mtwd_pkg::CLOCK_WIDTH-1:0];
         mtwd_pkg::REG_TEETH_PER_REV: cfg_teeth = data[7:0];
         mtwd_pkg::REG_COUNT_LIMIT:   cfg_count_limit = data[7:0];
         mtwd_pkg::REG_MARKER_EVERY:  cfg_marker_every = data[7:0];
         mtwd_pkg::REG_MARKER_LIMIT:  cfg_marker_limit = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Upper write data bits are random garbage that the block must mask off
   task automatic set_config(input logic [mtwd_pkg::CLOCK_WIDTH-1:0] clk,
                             input logic [7:0] teeth,
                             input logic [7:0] limit, input logic [7:0] every,
                             input logic [7:0] mlimit);
      drain_pipeline();
      write_reg(mtwd_pkg::REG_CLOCK_HZ, {2'($urandom), clk});
      write_reg(mtwd_pkg::REG_TEETH_PER_REV, {24'($urandom), teeth});
      write_reg(mtwd_pkg::REG_COUNT_LIMIT, {24'($urandom), limit});
      write_reg(mtwd_pkg::REG_MARKER_EVERY, {24'($urandom), every});
      write_reg(mtwd_pkg::REG_MARKER_LIMIT, {24'($urandom), mlimit});
   endtask

   function automatic logic [31:0] jittered(input logic [31:0] center, input logic [31:0] spread);
      return center - spread + $urandom_range(0, 2 * spread);
   endfunction

   // Synthetic trigger wheel: steady teeth with jitter, one long missing-tooth
   // period per turn, some doubled teeth, drift, and a little noise
   task automatic run_wheel(input int unsigned teeth_sent);
      logic [31:0] base;
      logic [31:0] period;
      int unsigned wheel_len;
      int unsigned pos;
      int unsigned pick;
      base = ($urandom >> $urandom_range(2, 31)) + 1;
      wheel_len = $urandom_range(3, 40);
      pos = 0;
      repeat (teeth_sent) begin
         pick = $urandom_range(0, 99);
         if (pos == wheel_len - 1)
            period = jittered(3 * base, (3 * base) / 20);
         else if (pick < 6)
            period = jittered(2 * base, base / 10);
         else if (pick < 14)
            period = $urandom >> $urandom_range(0, 31);
         else begin
            if (pick < 18) begin
               base = base - base / 16 + $urandom_range(0, base / 8);
               if (base > 32'h4000_0000)
                  base = 32'h4000_0000;
            end
            period = jittered(base, base / 20);
         end
         send_tooth(period);
         pos = (pos + 1) % wheel_len;
      end
   endtask

   task automatic test_directed_windows();
      // window edges are probed here: several pairs land exactly on a strict boundary
      send_tooth(32'd0);
      send_tooth(32'hFFFF_FFFF);
      send_tooth(32'd0);
      send_tooth(32'd0);
      send_tooth(32'd1000);
      send_tooth(32'd1000);
      send_tooth(32'd2000);
      send_tooth(32'd6000);
      send_tooth(32'd6000);
      send_tooth(32'd4800);
      send_tooth(32'd10560);
      send_tooth(32'd24288);
      send_tooth(32'd89865);
      send_tooth(32'd1);
      send_tooth(32'd1);
      send_tooth(32'd2);
      send_tooth(32'hFFFF_FFFF);
      send_tooth(32'hFFFF_FFFF);
      send_tooth(32'h8000_0000);
      send_tooth(32'h5555_5555);
      send_tooth(32'hAAAA_AAAA);
      send_tooth(32'd1000);
      send_tooth(32'd2500);
      send_tooth(32'd8750);
   endtask

   task automatic test_register_extremes();
      // speed saturates on tiny periods with a 1 GHz clock and one tooth
      set_config(30'd1000000000, 8'd1, 8'd1, 8'd1, 8'd255);
      for (int i = mtwd_pkg::REG_MARKER_LIMIT + 1; i < 8; i++)
         write_reg(3'(i), $urandom);
      send_tooth(32'd1);
      send_tooth(32'd1);
      send_tooth(32'd2);
      run_wheel(30);
      set_config(30'd1, 8'd255, 8'd255, 8'd255, 8'd1);
      run_wheel(30);
      // zero tooth count, zero marker spacing, zero limits
      set_config(30'h3FFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd0);
      send_tooth(32'd500);
      send_tooth(32'd500);
      send_tooth(32'd1000);
      run_wheel(30);
      set_config(mtwd_pkg::CLOCK_HZ_RESET, 8'd36, 8'd3, 8'd2, 8'd255);
      run_wheel(30);
      set_config(30'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_wheel(30);
   endtask

   task automatic test_wheel_sequences();
      repeat (3) begin
         set_config(30'($urandom_range(1, 1000000000)), 8'($urandom_range(1, 60)),
                    8'($urandom_range(1, 60)), 8'($urandom_range(1, 8)),
                    8'($urandom_range(1, 80)));
         run_wheel(60);
      end
   endtask

   task automatic test_count_saturation();
      logic [31:0] base;
      set_config(mtwd_pkg::CLOCK_HZ_RESET, 8'd36, 8'd200, 8'd5, 8'd255);
      idle_enable = 1'b0;
      base = $urandom_range(40, 100000);
      send_tooth(base);
      send_tooth(3 * base);
      send_tooth(base);
      repeat (265) send_tooth(jittered(base, base / 20));
      idle_enable = 1'b1;
   endtask

   task automatic test_ratio_noise();
      int unsigned ratio_edges[8] = '{8, 12, 18, 22, 23, 25, 35, 37};
      logic [63:0] scaled;
      logic [31:0] period;
      int unsigned pick;
      set_config(30'($urandom), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                 8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
      repeat (110) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            period = $urandom;
         else if (pick < 55)
            period = $urandom >> $urandom_range(0, 31);
         else if (pick < 75)
            period = (($urandom >> $urandom_range(4, 28)) + 1) * 10;
         else begin
            // land on or right next to a window edge
            scaled = {32'd0, last_period} * ratio_edges[$urandom_range(0, 7)] / 10;
            if (scaled > 64'hFFFF_FFFF)
               period = $urandom;
            else
               period = scaled[31:0] + $urandom_range(0, 2) - 1;
         end
         send_tooth(period);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(0, 99) < 8);
   end

   always @(posedge clock) begin : check_results
      tooth_result_type got;
      tooth_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_speed_rpm, rsp_gap_event, rsp_marker_event, rsp_tooth_index, rsp_synced};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: result transfer %0d with nothing pending", results_taken);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result %0d expected speed=%0d gap=%0b marker=%0b",
                           results_taken, want.speed_rpm, want.gap_event,
                           want.marker_event);
                  $display("       expected idx=%0d sync=%0b",
                           want.tooth_index, want.synced);
                  $display("       got      speed=%0d gap=%0b marker=%0b idx=%0d sync=%0b",
                           got.speed_rpm, got.gap_event, got.marker_event,
                           got.tooth_index, got.synced);
               end
            end
         end
         results_taken++;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_windows();
      test_register_extremes();
      test_wheel_sequences();
      test_count_saturation();
      test_ratio_noise();
      drain_pipeline();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
